### rtl/stereo_looper_beat_repeat_varispeed_core_macros.svh
// Assertion macros for the stereo looper core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef STEREO_LOOPER_BEAT_REPEAT_VARISPEED_CORE_MACROS_SVH
`define STEREO_LOOPER_BEAT_REPEAT_VARISPEED_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define SLVC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression that must never be true
`define SLVC_NEVER(lbl, expr, msg) \
    `SLVC_ASSERT(lbl, !(expr), msg)

`endif

### rtl/slvc_pkg.sv
// Shared constants, types and helpers for the stereo looper core.
// No dependencies.
`default_nettype none
package slvc_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int FRAC_BITS    = 16;
    localparam int BUFFER_DEPTH = 1152000;
    localparam int MAX_BEAT     = 144000;
    localparam int RESET_BEAT   = 24000;
    localparam int BEAT_SHIFT   = 3;      // eight beats per buffer

    localparam int IDX_W  = 21;           // store index
    localparam int INT_W  = IDX_W + 1;    // integer part of play position
    localparam int POS_W  = INT_W + FRAC_BITS;
    localparam int BEAT_W = 18;
    localparam int SPD_W  = 20;           // signed speed, FRAC_BITS fraction
    localparam int PROD_W = 37;           // divider dividend width
    localparam int DCNT_W = 6;
    localparam int WORD_W = 2 * SAMPLE_BITS;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(BUFFER_DEPTH - 1);
    localparam logic [BEAT_W-1:0] MAX_TAP    = BEAT_W'(MAX_BEAT);
    localparam logic [BEAT_W-1:0] RESET_BT   = BEAT_W'(RESET_BEAT);
    localparam logic [SPD_W-1:0]  UNIT_SPEED = SPD_W'(1) << FRAC_BITS;

    // item kinds
    localparam logic [2:0] KIND_SAMPLE = 3'd0;
    localparam logic [2:0] KIND_TAP    = 3'd1;
    localparam logic [2:0] KIND_REPEAT = 3'd2;
    localparam logic [2:0] KIND_SPEED  = 3'd3;
    localparam logic [2:0] KIND_DRY    = 3'd4;

    // play modes
    localparam logic [1:0] MODE_DRY    = 2'd0;
    localparam logic [1:0] MODE_REPEAT = 2'd1;
    localparam logic [1:0] MODE_SPEED  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_REP_RD, ST_REP_CAP, ST_SPD_MOD, ST_SPD_RD, ST_GL_MUL,
        ST_GL_GO, ST_GL_DIV, ST_SPD_ADV, ST_SPD_WRAP, ST_K2_MOD, ST_K2_SET, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // speed codes: -2, -1, -0.5, 0, 0.5, 1, 2, 4
    function automatic logic signed [SPD_W-1:0] speed_of(input logic [2:0] code);
        logic signed [SPD_W-1:0] half;
        half = SPD_W'(1) << (FRAC_BITS - 1);
        case (code)
            3'd0:    speed_of = -(half <<< 2);
            3'd1:    speed_of = -(half <<< 1);
            3'd2:    speed_of = -half;
            3'd3:    speed_of = '0;
            3'd4:    speed_of = half;
            3'd5:    speed_of = half <<< 1;
            3'd6:    speed_of = half <<< 2;
            default: speed_of = half <<< 3;
        endcase
    endfunction

    // last store index for a beat: eight beats less one, clamped to the store
    function automatic logic [IDX_W-1:0] limit_of(input logic [BEAT_W-1:0] beat);
        logic [IDX_W+1:0] v;
        v = (IDX_W+2)'(beat) << BEAT_SHIFT;
        if (v != '0) v = v - 1'b1;
        if (v > (IDX_W+2)'(LAST_IDX)) v = (IDX_W+2)'(LAST_IDX);
        limit_of = v[IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

### rtl/slvc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on slvc_pkg.
`default_nettype none
module slvc_div
    import slvc_pkg::*;
(
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire  t_div_req          i_req,
    input  wire  [PROD_W-1:0]       i_dividend,
    input  wire  [IDX_W-1:0]        i_divisor,
    output t_div_stat               o_stat,
    output logic [PROD_W-1:0]       o_quot,
    output logic [IDX_W-1:0]        o_rem
);

    logic [PROD_W-1:0] r_q;
    logic [IDX_W-1:0]  r_r;
    logic [IDX_W-1:0]  r_d;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [IDX_W:0]    w_trial;
    logic              w_fit;

    // shift in next dividend bit and try the subtract
    assign w_trial = {r_r, r_q[PROD_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(PROD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[PROD_W-2:0], w_fit};
            r_r <= w_fit ? IDX_W'(w_trial - {1'b0, r_d}) : w_trial[IDX_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_q;
    assign o_rem       = r_r;

endmodule
`default_nettype wire

### rtl/stereo_looper_beat_repeat_varispeed_core.sv
// Dry samples go straight to the output register; beat repeat first reads and
// captures a stored word; variable speed adds a divider reduction of the play
// position when needed and a glide division during a glide, both on the shared 37-step divider.
// A beat repeat press may also need a reduction. One item at a time: a new one is taken only in idle.
// Reset (synchronous, active low) restores the default beat and speed at
// once; the sample store is not cleared.
`default_nettype none
`include "stereo_looper_beat_repeat_varispeed_core_macros.svh"
module stereo_looper_beat_repeat_varispeed_core
    import slvc_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [39:0] s_axis_tdata,   // left_in[15:0], right_in[31:16], speed_code[34:32]
    input  wire  [2:0]  s_axis_tuser,   // kind[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // left_out[15:0], right_out[31:16]
);

    t_state r_state, n_state;

    logic [IDX_W-1:0]         r_rec, r_lf, r_ll, r_wl, r_mod, r_addr;
    logic [POS_W-1:0]         r_pos;
    logic [1:0]               r_mode;
    logic signed [SPD_W-1:0]  r_cur, r_gst, r_tgt;
    logic [BEAT_W-1:0]        r_glide, r_tap, r_beat;
    logic [WORD_W-1:0]        r_rd_data, r_res, r_out;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_neg;
    logic signed [POS_W+1:0]  r_sum;
    logic                     r_ov;

    logic [WORD_W-1:0]        mem [0:BUFFER_DEPTH-1];

    logic                     w_acc;
    logic [2:0]               w_kind;
    logic [IDX_W-1:0]         w_len;
    logic [INT_W-1:0]         w_pint;
    logic                     w_load_out;
    logic                     w_div_wait;
    t_div_req                 w_req;
    t_div_stat                w_dstat;
    logic [PROD_W-1:0]        w_dvd, w_quot;
    logic [IDX_W-1:0]         w_dvs, w_rem;

    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_kind  = s_axis_tuser;
    assign w_len   = r_wl + 1'b1;
    assign w_pint  = r_pos[POS_W-1:FRAC_BITS];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_load_out = (r_state == ST_OUT) && (!r_ov || m_axis_tready);
    assign w_div_wait = (r_state == ST_SPD_MOD) || (r_state == ST_GL_DIV) ||
                        (r_state == ST_K2_MOD);

    slvc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_stat     (w_dstat),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and divider requests
    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_dvd       = PROD_W'(w_pint);
        w_dvs       = w_len;
        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (w_kind)
                        KIND_SAMPLE: begin
                            if (r_mode == MODE_REPEAT) begin
                                n_state = ST_REP_RD;
                            end else if (r_mode == MODE_SPEED) begin
                                if (w_pint < INT_W'(w_len)) begin
                                    n_state = ST_SPD_RD;
                                end else begin
                                    w_req.start = 1'b1;
                                    n_state     = ST_SPD_MOD;
                                end
                            end else begin
                                n_state = ST_OUT;
                            end
                        end
                        KIND_REPEAT: begin
                            w_dvd = PROD_W'(r_rec);
                            if (r_rec < w_len) begin
                                n_state = ST_K2_SET;
                            end else begin
                                w_req.start = 1'b1;
                                n_state     = ST_K2_MOD;
                            end
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_REP_RD:  n_state = ST_REP_CAP;
            ST_REP_CAP: n_state = ST_OUT;
            ST_SPD_MOD: if (w_dstat.done) n_state = ST_SPD_RD;
            ST_SPD_RD: begin
                if (r_cur != r_tgt && r_beat != '0 && r_glide < r_beat)
                    n_state = ST_GL_MUL;
                else
                    n_state = ST_SPD_ADV;
            end
            ST_GL_MUL:  n_state = ST_GL_GO;
            ST_GL_GO: begin
                w_req.start = 1'b1;
                w_dvd       = r_prod;
                w_dvs       = IDX_W'(r_beat);
                n_state     = ST_GL_DIV;
            end
            ST_GL_DIV:   if (w_dstat.done) n_state = ST_SPD_ADV;
            ST_SPD_ADV:  n_state = ST_SPD_WRAP;
            ST_SPD_WRAP: n_state = ST_OUT;
            ST_K2_MOD:   if (w_dstat.done) n_state = ST_K2_SET;
            ST_K2_SET:   n_state = ST_IDLE;
            ST_OUT:      if (w_load_out) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // sample store: write on sample items, registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && w_kind == KIND_SAMPLE) mem[r_rec] <= s_axis_tdata[WORD_W-1:0];
        r_rd_data <= mem[r_addr];
    end

    // looper state and datapath
    always_ff @(posedge i_clk) begin
        logic [INT_W-1:0]        nxt;
        logic signed [IDX_W:0]   diff;
        logic [IDX_W:0]          mag;
        logic signed [IDX_W:0]   q;
        logic signed [POS_W+1:0] span;
        logic [INT_W-1:0]        lsum;
        nxt  = w_pint + 1'b1;
        diff = (IDX_W+1)'(r_tgt) - (IDX_W+1)'(r_gst);
        mag  = diff[IDX_W] ? (IDX_W+1)'(-diff) : diff;
        q    = (IDX_W+1)'(w_quot);
        span = (POS_W+2)'({w_len, {FRAC_BITS{1'b0}}});
        lsum = INT_W'(r_mod) + INT_W'(r_beat);
        if (!i_rst_n) begin
            r_rec   <= '0;
            r_pos   <= '0;
            r_mode  <= MODE_DRY;
            r_cur   <= UNIT_SPEED;
            r_gst   <= UNIT_SPEED;
            r_tgt   <= UNIT_SPEED;
            r_glide <= '0;
            r_lf    <= '0;
            r_ll    <= IDX_W'(RESET_BEAT);
            r_tap   <= MAX_TAP;
            r_beat  <= RESET_BT;
            r_wl    <= limit_of(RESET_BT);
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_acc) begin
                        case (w_kind)
                            KIND_SAMPLE: begin
                                r_rec  <= (r_rec + 1'b1 > r_wl) ? '0 : r_rec + 1'b1;
                                if (r_tap < MAX_TAP) r_tap <= r_tap + 1'b1;
                                r_res  <= s_axis_tdata[WORD_W-1:0];
                                r_addr <= w_pint[IDX_W-1:0];
                                r_mod  <= w_pint[IDX_W-1:0];
                            end
                            KIND_TAP: begin
                                if (r_tap != '0 && r_tap < MAX_TAP) begin
                                    r_beat <= r_tap;
                                    r_wl   <= limit_of(r_tap);
                                end
                                r_tap <= '0;
                            end
                            KIND_REPEAT: r_mod <= r_rec;
                            KIND_SPEED: begin
                                if (r_mode == MODE_DRY) begin
                                    r_mode <= MODE_SPEED;
                                    r_cur  <= speed_of(s_axis_tdata[34:32]);
                                    r_tgt  <= speed_of(s_axis_tdata[34:32]);
                                end else if (r_mode == MODE_SPEED) begin
                                    if (r_cur == r_tgt) begin
                                        r_glide <= '0;
                                        r_gst   <= r_cur;
                                    end
                                    r_tgt <= speed_of(s_axis_tdata[34:32]);
                                end
                                r_pos <= {1'b0, r_rec, {FRAC_BITS{1'b0}}};
                            end
                            KIND_DRY: r_mode <= MODE_DRY;
                            default: ;
                        endcase
                    end
                end
                // beat repeat: step the integer position around the loop
                ST_REP_CAP: begin
                    r_res <= r_rd_data;
                    if (nxt == INT_W'(r_ll) + 1'b1) nxt = INT_W'(r_lf);
                    if (nxt > INT_W'(r_wl)) nxt = '0;
                    r_pos <= {nxt, {FRAC_BITS{1'b0}}};
                end
                ST_SPD_MOD: if (w_dstat.done) r_mod <= w_rem;
                // reduced position, issue read, settle speed when no glide math
                ST_SPD_RD: begin
                    r_pos  <= {1'b0, r_mod, r_pos[FRAC_BITS-1:0]};
                    r_addr <= r_mod;
                    if (r_cur != r_tgt && (r_beat == '0 || r_glide >= r_beat)) begin
                        r_cur <= r_tgt;
                        if (r_glide != '1) r_glide <= r_glide + 1'b1;
                    end
                end
                ST_GL_MUL: begin
                    r_prod <= PROD_W'(mag[SPD_W-1:0]) * PROD_W'(r_glide);
                    r_neg  <= diff[IDX_W];
                end
                ST_GL_DIV: begin
                    if (w_dstat.done) begin
                        r_cur <= SPD_W'((IDX_W+1)'(r_gst) + (r_neg ? -q : q));
                        if (r_glide != '1) r_glide <= r_glide + 1'b1;
                    end
                end
                ST_SPD_ADV: r_sum <= (POS_W+2)'({2'b00, r_pos}) + (POS_W+2)'(r_cur);
                ST_SPD_WRAP: begin
                    r_res <= r_rd_data;
                    if (r_sum < 0)          r_pos <= POS_W'(r_sum + span);
                    else if (r_sum >= span) r_pos <= POS_W'(r_sum - span);
                    else                    r_pos <= POS_W'(r_sum);
                end
                ST_K2_MOD: if (w_dstat.done) r_mod <= w_rem;
                // beat repeat press: loop bounds from the record point
                ST_K2_SET: begin
                    r_mode <= MODE_REPEAT;
                    r_lf   <= r_mod;
                    r_ll   <= (lsum >= INT_W'(w_len)) ? IDX_W'(lsum - INT_W'(w_len))
                                                      : IDX_W'(lsum);
                    r_pos  <= {1'b0, r_mod, {FRAC_BITS{1'b0}}};
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load_out) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
        if (w_load_out) r_out <= r_res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_out;

    `SLVC_NEVER(a_rec_in_store, r_rec > LAST_IDX, "record index beyond store")
    `SLVC_NEVER(a_mode_code, r_mode == 2'd3, "invalid play mode")
    `SLVC_ASSERT(a_div_owner, w_dstat.busy |-> w_div_wait, "divider busy outside a wait state")
    `SLVC_ASSERT(a_ready_div_idle, s_axis_tready |-> !w_dstat.busy, "ready while divider busy")

endmodule
`default_nettype wire
